/* src/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// Contiguous fit allocator package
// Shared types, codes and field widths for the allocator and its channels.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int OWNER_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int START_W  = 8;
  localparam int END_W    = 9;
  localparam int POLICY_W = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOOWNER = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TSCAN,
    S_USCAN,
    S_PICK,
    S_MARK,
    S_TWRITE,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic    init;
    logic    step;
    logic    busy;
    logic    wrap_pass;
    policy_t policy;
  } run_ctl_t;

  typedef struct packed {
    logic hit;
    logic best_vld;
  } run_sts_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_sts_t;

endpackage

/* src/cfa_channels.sv */
// ----------------------------------------------------------------------------
// Allocator channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface cfa_req_if;
  logic                           valid;
  logic                           ready;
  cfa_pkg::opcode_t               opcode;
  logic [cfa_pkg::OWNER_W-1:0]    owner_id;
  logic [cfa_pkg::SIZE_W-1:0]     request_size;

  modport source (output valid, output opcode, output owner_id, output request_size,
                  input ready);
  modport sink (input valid, input opcode, input owner_id, input request_size,
                output ready);
endinterface

interface cfa_rsp_if;
  logic                           valid;
  logic                           ready;
  cfa_pkg::status_t               status;
  logic [cfa_pkg::START_W-1:0]    range_start;
  logic [cfa_pkg::END_W-1:0]      range_end;

  modport source (output valid, output status, output range_start, output range_end,
                  input ready);
  modport sink (input valid, input status, input range_start, input range_end,
                output ready);
endinterface

/* src/cfa_run_unit.sv */
// ----------------------------------------------------------------------------
// Free run tracker
// Follows free runs one unit per step and reports a fit or the best run.
// ----------------------------------------------------------------------------
module cfa_run_unit #(
  parameter int MEM_UNITS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfa_pkg::run_ctl_t             ctl,
  input  logic [$clog2(MEM_UNITS+1)-1:0] idx,
  input  logic [$clog2(MEM_UNITS+1)-1:0] init_start,
  input  logic [cfa_pkg::SIZE_W-1:0]    size,
  input  logic [$clog2(MEM_UNITS)-1:0]  nf_ptr,
  output cfa_pkg::run_sts_t             sts,
  output logic [$clog2(MEM_UNITS+1)-1:0] run_start,
  output logic [$clog2(MEM_UNITS+1)-1:0] best_start
);

  localparam int UCW = $clog2(MEM_UNITS+1);
  localparam int SZW = (UCW > cfa_pkg::SIZE_W) ? UCW : cfa_pkg::SIZE_W;

  logic [UCW-1:0] run_start_r;
  logic [UCW-1:0] run_len_r;
  logic [UCW-1:0] best_start_r;
  logic [UCW-1:0] best_len_r;
  logic           best_vld_r;
  logic [UCW-1:0] len_inc;
  logic           fit_mode;
  logic           below_ptr;
  logic           better;
  logic           close_upd;
  logic           hit;

  always_comb begin
    len_inc   = UCW'(run_len_r + 1'b1);
    fit_mode  = (ctl.policy == cfa_pkg::POL_FIRST) || (ctl.policy == cfa_pkg::POL_NEXT);
    below_ptr = run_start_r < UCW'(nf_ptr);
    hit = ctl.step && !ctl.busy && fit_mode && (SZW'(len_inc) == SZW'(size)) &&
          (!ctl.wrap_pass || below_ptr);
    if (ctl.policy == cfa_pkg::POL_BEST) begin
      better = run_len_r < best_len_r;
    end else begin
      better = run_len_r > best_len_r;
    end
    close_upd = ctl.step && ctl.busy && !fit_mode && (run_len_r != '0) &&
                (SZW'(run_len_r) >= SZW'(size)) && (!best_vld_r || better);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (ctl.init) begin
      best_vld_r <= 1'b0;
    end else if (close_upd) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      run_start_r <= init_start;
      run_len_r   <= '0;
    end else if (ctl.step) begin
      if (ctl.busy) begin
        run_start_r <= UCW'(idx + 1'b1);
        run_len_r   <= '0;
      end else begin
        run_len_r <= len_inc;
      end
    end
    if (close_upd) begin
      best_start_r <= run_start_r;
      best_len_r   <= run_len_r;
    end
  end

  assign sts.hit      = hit;
  assign sts.best_vld = best_vld_r;
  assign run_start    = run_start_r;
  assign best_start   = best_start_r;

endmodule

/* src/cfa_seq.sv */
// ----------------------------------------------------------------------------
// Allocator sequencer
// Holds the busy map and owner table and steps each request through them.
// ----------------------------------------------------------------------------
module cfa_seq #(
  parameter int MEM_UNITS     = 256,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  cfa_pkg::opcode_t               opcode,
  input  logic [cfa_pkg::OWNER_W-1:0]    owner_id,
  input  logic [cfa_pkg::SIZE_W-1:0]     request_size,
  input  cfa_pkg::policy_t               policy,
  input  logic                           res_take,
  output cfa_pkg::seq_sts_t              sts,
  output cfa_pkg::status_t               res_status,
  output logic [$clog2(MEM_UNITS)-1:0]   res_start,
  output logic [$clog2(MEM_UNITS+1)-1:0] res_end
);

  localparam int UAW = $clog2(MEM_UNITS);
  localparam int UCW = $clog2(MEM_UNITS+1);
  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int TCW = $clog2(TABLE_ENTRIES+1);
  localparam int IW  = (UCW > TCW) ? UCW : TCW;
  localparam int SZW = (UCW > cfa_pkg::SIZE_W) ? UCW : cfa_pkg::SIZE_W;
  localparam int TEW = 1 + cfa_pkg::OWNER_W + UAW + UCW;
  localparam int CLR_LAST = ((MEM_UNITS > TABLE_ENTRIES) ? MEM_UNITS : TABLE_ENTRIES) - 1;

  logic           busy_mem [MEM_UNITS];
  logic [TEW-1:0] tbl_mem  [TABLE_ENTRIES];

  cfa_pkg::fsm_state_t         state_r, state_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  cfa_pkg::opcode_t            op_r, op_nxt;
  logic [cfa_pkg::OWNER_W-1:0] owner_r, owner_nxt;
  logic [cfa_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [TAW-1:0]              slot_r, slot_nxt;
  logic [UAW-1:0]              start_r, start_nxt;
  logic [UCW-1:0]              end_r, end_nxt;
  logic                        mark_val_r, mark_val_nxt;
  logic                        pass_r, pass_nxt;
  logic [UAW-1:0]              ptr_r, ptr_nxt;
  cfa_pkg::status_t            status_r, status_nxt;

  logic                        busy_q_r;
  logic [TEW-1:0]              tbl_q_r;
  logic                        busy_we;
  logic                        busy_wd;
  logic [UAW-1:0]              busy_wa;
  logic                        tbl_we;
  logic [TEW-1:0]              tbl_wd;
  logic [TAW-1:0]              tbl_wa;

  logic                        e_valid;
  logic [cfa_pkg::OWNER_W-1:0] e_owner;
  logic [UAW-1:0]              e_start;
  logic [UCW-1:0]              e_end;
  logic                        match;
  logic                        at_end;
  logic [UCW-1:0]              nf_start;

  cfa_pkg::run_ctl_t           run_ctl;
  cfa_pkg::run_sts_t           run_sts;
  logic [UCW-1:0]              init_start;
  logic [UCW-1:0]              run_start;
  logic [UCW-1:0]              best_start;

  cfa_run_unit #(
    .MEM_UNITS (MEM_UNITS)
  ) u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (run_ctl),
    .idx        (idx_r[UCW-1:0]),
    .init_start (init_start),
    .size       (size_r),
    .nf_ptr     (ptr_r),
    .sts        (run_sts),
    .run_start  (run_start),
    .best_start (best_start)
  );

  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
    busy_q_r <= busy_mem[idx_nxt[UAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q_r <= tbl_mem[idx_nxt[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfa_pkg::S_CLEAR;
      idx_r   <= '0;
      ptr_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ptr_r   <= ptr_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    owner_r    <= owner_nxt;
    size_r     <= size_nxt;
    slot_r     <= slot_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    mark_val_r <= mark_val_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    e_valid  = tbl_q_r[TEW-1];
    e_owner  = tbl_q_r[TEW-2 -: cfa_pkg::OWNER_W];
    e_start  = tbl_q_r[UCW +: UAW];
    e_end    = tbl_q_r[UCW-1:0];
    at_end   = idx_r == IW'(MEM_UNITS);
    nf_start = (policy == cfa_pkg::POL_NEXT) ? UCW'(ptr_r) : '0;
    if (op_r == cfa_pkg::OP_ALLOC) begin
      match = !e_valid;
    end else begin
      match = e_valid && (e_owner == owner_r);
    end

    run_ctl.init      = 1'b0;
    run_ctl.step      = 1'b0;
    run_ctl.busy      = at_end || busy_q_r;
    run_ctl.wrap_pass = pass_r;
    run_ctl.policy    = policy;
    init_start        = nf_start;

    case (state_r)
      cfa_pkg::S_TSCAN: begin
        run_ctl.init = match && (op_r == cfa_pkg::OP_ALLOC) && (size_r != '0) &&
                       (SZW'(size_r) <= SZW'(MEM_UNITS));
      end
      cfa_pkg::S_USCAN: begin
        if (at_end && (policy == cfa_pkg::POL_NEXT) && !pass_r && (ptr_r != '0)) begin
          run_ctl.init = 1'b1;
          init_start   = '0;
        end else begin
          run_ctl.step = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    op_nxt       = op_r;
    owner_nxt    = owner_r;
    size_nxt     = size_r;
    slot_nxt     = slot_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    mark_val_nxt = mark_val_r;
    pass_nxt     = pass_r;
    ptr_nxt      = ptr_r;
    status_nxt   = status_r;

    busy_we = 1'b0;
    busy_wd = mark_val_r;
    busy_wa = idx_r[UAW-1:0];
    tbl_we  = 1'b0;
    tbl_wd  = '0;
    tbl_wa  = slot_r;

    case (state_r)
      cfa_pkg::S_CLEAR: begin
        busy_we = idx_r < IW'(MEM_UNITS);
        busy_wd = 1'b0;
        tbl_we  = idx_r < IW'(TABLE_ENTRIES);
        tbl_wa  = idx_r[TAW-1:0];
        if (idx_r == IW'(CLR_LAST)) begin
          idx_nxt   = '0;
          state_nxt = cfa_pkg::S_IDLE;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      cfa_pkg::S_IDLE: begin
        if (go) begin
          op_nxt    = opcode;
          owner_nxt = owner_id;
          size_nxt  = request_size;
          idx_nxt   = '0;
          state_nxt = cfa_pkg::S_TSCAN;
        end
      end
      cfa_pkg::S_TSCAN: begin
        if (match) begin
          slot_nxt = idx_r[TAW-1:0];
          if (op_r == cfa_pkg::OP_FREE) begin
            start_nxt    = e_start;
            end_nxt      = e_end;
            idx_nxt      = IW'(e_start);
            mark_val_nxt = 1'b0;
            state_nxt    = cfa_pkg::S_MARK;
          end else if ((size_r == '0) || (SZW'(size_r) > SZW'(MEM_UNITS))) begin
            status_nxt = cfa_pkg::ST_NOFIT;
            start_nxt  = '0;
            end_nxt    = '0;
            state_nxt  = cfa_pkg::S_DONE;
          end else begin
            idx_nxt      = IW'(nf_start);
            pass_nxt     = 1'b0;
            mark_val_nxt = 1'b1;
            state_nxt    = cfa_pkg::S_USCAN;
          end
        end else if (idx_r == IW'(TABLE_ENTRIES - 1)) begin
          if (op_r == cfa_pkg::OP_ALLOC) begin
            status_nxt = cfa_pkg::ST_FULL;
          end else begin
            status_nxt = cfa_pkg::ST_NOOWNER;
          end
          start_nxt = '0;
          end_nxt   = '0;
          state_nxt = cfa_pkg::S_DONE;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      cfa_pkg::S_USCAN: begin
        if (run_sts.hit) begin
          start_nxt = run_start[UAW-1:0];
          end_nxt   = UCW'(SZW'(run_start) + SZW'(size_r));
          idx_nxt   = IW'(run_start);
          state_nxt = cfa_pkg::S_MARK;
        end else if (at_end) begin
          if ((policy == cfa_pkg::POL_BEST) || (policy == cfa_pkg::POL_WORST)) begin
            state_nxt = cfa_pkg::S_PICK;
          end else if ((policy == cfa_pkg::POL_NEXT) && !pass_r && (ptr_r != '0)) begin
            idx_nxt  = '0;
            pass_nxt = 1'b1;
          end else begin
            status_nxt = cfa_pkg::ST_NOFIT;
            start_nxt  = '0;
            end_nxt    = '0;
            state_nxt  = cfa_pkg::S_DONE;
          end
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      cfa_pkg::S_PICK: begin
        if (run_sts.best_vld) begin
          start_nxt = best_start[UAW-1:0];
          end_nxt   = UCW'(SZW'(best_start) + SZW'(size_r));
          idx_nxt   = IW'(best_start);
          state_nxt = cfa_pkg::S_MARK;
        end else begin
          status_nxt = cfa_pkg::ST_NOFIT;
          start_nxt  = '0;
          end_nxt    = '0;
          state_nxt  = cfa_pkg::S_DONE;
        end
      end
      cfa_pkg::S_MARK: begin
        busy_we = 1'b1;
        if (IW'(idx_r + 1'b1) == IW'(end_r)) begin
          state_nxt = cfa_pkg::S_TWRITE;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      cfa_pkg::S_TWRITE: begin
        tbl_we = 1'b1;
        if (op_r == cfa_pkg::OP_ALLOC) begin
          tbl_wd = {1'b1, owner_r, start_r, end_r};
          if (policy == cfa_pkg::POL_NEXT) begin
            if (end_r == UCW'(MEM_UNITS)) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = end_r[UAW-1:0];
            end
          end
        end
        status_nxt = cfa_pkg::ST_OK;
        state_nxt  = cfa_pkg::S_DONE;
      end
      cfa_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = cfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cfa_pkg::S_IDLE;
      end
    endcase
  end

  assign sts.idle   = state_r == cfa_pkg::S_IDLE;
  assign sts.done   = state_r == cfa_pkg::S_DONE;
  assign res_status = status_r;
  assign res_start  = start_r;
  assign res_end    = end_r;

endmodule

/* src/contiguous_fit_allocator_top.sv */
// ----------------------------------------------------------------------------
// Contiguous fit allocator
// First, next, best or worst fit allocation of unit ranges with an owner table.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Payload
// in_req    in         valid/ready    opcode, owner_id, request_size
// out_rsp   out        valid/ready    status, range_start, range_end
// cfg       in         cfg_wr_en      cfg_wr_data (placement policy)
//
// After reset a clearing pass over the busy map and the owner table runs
// before the first request is taken. An allocation runs a slot search of the
// owner table, a scan of the busy map (a second pass for a wrapping next fit,
// a pick step for best and worst fit), the marking of request_size units,
// a table write and a done state. A free runs the slot search, the marking of
// its range and the same two states. The busy map is read one unit per cycle.
// A result waits in the output register while a new request is taken.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator_top #(
  parameter int MEM_UNITS     = 256,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cfa_req_if.sink                        in_req,
  cfa_rsp_if.source                      out_rsp,
  input  logic                           cfg_wr_en,
  input  logic [cfa_pkg::POLICY_W-1:0]   cfg_wr_data
);

  localparam int UAW = $clog2(MEM_UNITS);
  localparam int UCW = $clog2(MEM_UNITS+1);

  cfa_pkg::policy_t              policy_r;
  cfa_pkg::seq_sts_t             seq_sts;
  cfa_pkg::status_t              res_status;
  logic [UAW-1:0]                res_start;
  logic [UCW-1:0]                res_end;
  logic [31:0]                   start_ext;
  logic [31:0]                   end_ext;
  logic                          go;
  logic                          res_take;
  logic                          out_valid_r;
  cfa_pkg::status_t              out_status_r;
  logic [cfa_pkg::START_W-1:0]   out_start_r;
  logic [cfa_pkg::END_W-1:0]     out_end_r;

  assign go       = in_req.valid && in_req.ready;
  assign res_take = !out_valid_r || out_rsp.ready;

  cfa_seq #(
    .MEM_UNITS     (MEM_UNITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .opcode       (in_req.opcode),
    .owner_id     (in_req.owner_id),
    .request_size (in_req.request_size),
    .policy       (policy_r),
    .res_take     (res_take),
    .sts          (seq_sts),
    .res_status   (res_status),
    .res_start    (res_start),
    .res_end      (res_end)
  );

  assign start_ext = 32'(res_start);
  assign end_ext   = 32'(res_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= cfa_pkg::POL_FIRST;
    end else if (cfg_wr_en) begin
      policy_r <= cfa_pkg::policy_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_sts.done && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_sts.done && res_take) begin
      out_status_r <= res_status;
      out_start_r  <= start_ext[cfa_pkg::START_W-1:0];
      out_end_r    <= end_ext[cfa_pkg::END_W-1:0];
    end
  end

  assign in_req.ready        = seq_sts.idle;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.range_start = out_start_r;
  assign out_rsp.range_end   = out_end_r;

  // A taken request keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> !in_req.ready)
    else $error("request taken while the previous one was still starting");

  // A new result is only loaded while a request is being worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> !$past(in_req.ready))
    else $error("result appeared without a request in progress");

  a_fail_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_rsp.status != cfa_pkg::ST_OK)) |->
      ((out_rsp.range_start == '0) && (out_rsp.range_end == '0)))
    else $error("failed request reported a non-zero range");

endmodule
